### rtl/mers_pkg.sv
// ----------------------------------------------------------------------------
// mers_pkg: shared constants and types
// constants of the fixed-point exponential and the residual sum
// ----------------------------------------------------------------------------
package mers_pkg;

    localparam int MAX_TERMS_DEF = 3;
    localparam int TAYLOR_TERMS  = 13;
    localparam int EXP_CUTOFF    = 23;
    localparam logic [31:0] EXP_M1_Q32 = 32'd1580030169;
    localparam logic [63:0] SUM_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;

    // register indexes of the configuration port
    localparam logic [2:0] REG_TERM_COUNT = 3'd0;
    localparam logic [2:0] REG_AMP_1      = 3'd1;
    localparam logic [2:0] REG_TC_1       = 3'd2;
    localparam logic [2:0] REG_AMP_2      = 3'd3;
    localparam logic [2:0] REG_TC_2       = 3'd4;
    localparam logic [2:0] REG_AMP_3      = 3'd5;
    localparam logic [2:0] REG_TC_3       = 3'd6;

    // request to the exponential unit
    typedef struct packed {
        logic        start;
        logic [31:0] x;
        logic [31:0] tc;
        logic [31:0] amp;
    } term_req_t;

    // answer of the exponential unit
    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } term_rsp_t;

endpackage

### rtl/mers_term_unit.sv
// ----------------------------------------------------------------------------
// mers_term_unit: one term amp * exp(-x / tc)
// restoring divider; taylor series, power and amplitude steps on one shared multiplier
// ----------------------------------------------------------------------------
module mers_term_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  mers_pkg::term_req_t req,
    output mers_pkg::term_rsp_t rsp
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_TAY  = 3'd2;
    localparam logic [2:0] ST_POW  = 3'd3;
    localparam logic [2:0] ST_AMP  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;
    localparam logic [2:0] ST_RCP  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] tc_reg, amp_reg;
    logic [32:0] t_reg, t_next;
    logic signed [35:0] s_reg, s_next;
    logic [32:0] e_reg, e_next;
    logic [4:0]  n_reg, n_next;
    logic [31:0] val_reg, val_next;

    // shared multiplier 33 x 32
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;
    logic [32:0] rem_sh;
    logic [32:0] tk;
    logic [32:0] rcp_m;
    logic [5:0]  rcp_sh;
    logic signed [35:0] s_upd;

    assign mul_p = mul_a * mul_b;
    assign rem_sh = {rem_reg[31:0], quo_reg[63]};

    always_comb
    begin
        mul_a = t_reg;
        mul_b = quo_reg[31:0];
        case (state_reg)
            ST_RCP:  begin mul_a = rcp_m; mul_b = t_reg[31:0]; end
            ST_POW:  begin mul_a = e_reg; mul_b = mers_pkg::EXP_M1_Q32; end
            ST_AMP:  begin mul_a = e_reg; mul_b = amp_reg; end
            default: begin mul_a = t_reg; mul_b = quo_reg[31:0]; end
        endcase
    end

    // divide by the term index: multiply by a rounded-up reciprocal, then shift
    always_comb
    begin
        case (cnt_reg[3:0])
            4'd1:    begin rcp_m = 33'((65'd1 << 32) / 65'd1 + 65'd1);  rcp_sh = 6'd32; end
            4'd2:    begin rcp_m = 33'((65'd1 << 33) / 65'd2 + 65'd1);  rcp_sh = 6'd33; end
            4'd3:    begin rcp_m = 33'((65'd1 << 34) / 65'd3 + 65'd1);  rcp_sh = 6'd34; end
            4'd4:    begin rcp_m = 33'((65'd1 << 34) / 65'd4 + 65'd1);  rcp_sh = 6'd34; end
            4'd5:    begin rcp_m = 33'((65'd1 << 35) / 65'd5 + 65'd1);  rcp_sh = 6'd35; end
            4'd6:    begin rcp_m = 33'((65'd1 << 35) / 65'd6 + 65'd1);  rcp_sh = 6'd35; end
            4'd7:    begin rcp_m = 33'((65'd1 << 35) / 65'd7 + 65'd1);  rcp_sh = 6'd35; end
            4'd8:    begin rcp_m = 33'((65'd1 << 35) / 65'd8 + 65'd1);  rcp_sh = 6'd35; end
            4'd9:    begin rcp_m = 33'((65'd1 << 36) / 65'd9 + 65'd1);  rcp_sh = 6'd36; end
            4'd10:   begin rcp_m = 33'((65'd1 << 36) / 65'd10 + 65'd1); rcp_sh = 6'd36; end
            4'd11:   begin rcp_m = 33'((65'd1 << 36) / 65'd11 + 65'd1); rcp_sh = 6'd36; end
            4'd12:   begin rcp_m = 33'((65'd1 << 36) / 65'd12 + 65'd1); rcp_sh = 6'd36; end
            4'd13:   begin rcp_m = 33'((65'd1 << 36) / 65'd13 + 65'd1); rcp_sh = 6'd36; end
            default: begin rcp_m = 33'd0; rcp_sh = 6'd32; end
        endcase
        tk    = 33'(mul_p >> rcp_sh);
        s_upd = cnt_reg[0] ? s_reg - $signed({3'd0, tk}) : s_reg + $signed({3'd0, tk});
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        t_next     = t_reg;
        s_next     = s_reg;
        e_next     = e_reg;
        n_next     = n_reg;
        val_next   = val_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    if (req.tc == 32'd0)
                    begin
                        val_next   = 32'd0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        quo_next   = {req.x, 32'd0};
                        rem_next   = 33'd0;
                        cnt_next   = 7'd64;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                if (rem_sh >= {1'b0, tc_reg})
                begin
                    rem_next = rem_sh - {1'b0, tc_reg};
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    if (quo_next[63:32] >= 32'(mers_pkg::EXP_CUTOFF))
                    begin
                        val_next   = 32'd0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        n_next     = quo_next[36:32];
                        t_next     = 33'h1_0000_0000;
                        s_next     = 36'sh1_0000_0000;
                        cnt_next   = 7'd1;
                        state_next = ST_TAY;
                    end
                end
            end
            ST_TAY:
            begin
                // previous term times the fraction
                t_next     = mul_p[64:32];
                state_next = ST_RCP;
            end
            ST_RCP:
            begin
                t_next = tk;
                s_next = s_upd;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(mers_pkg::TAYLOR_TERMS))
                begin
                    if (s_upd < 0)
                        e_next = 33'd0;
                    else if (s_upd > 36'sh1_0000_0000)
                        e_next = 33'h1_0000_0000;
                    else
                        e_next = s_upd[32:0];
                    state_next = ST_POW;
                end
                else
                    state_next = ST_TAY;
            end
            ST_POW:
            begin
                if (n_reg == 5'd0)
                    state_next = ST_AMP;
                else
                begin
                    e_next = 33'((mul_p + 65'h8000_0000) >> 32);
                    n_next = n_reg - 5'd1;
                end
            end
            ST_AMP:
            begin
                val_next   = 32'((mul_p + 65'h8000_0000) >> 32);
                state_next = ST_DONE;
            end
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        t_reg   <= t_next;
        s_reg   <= s_next;
        e_reg   <= e_next;
        n_reg   <= n_next;
        val_reg <= val_next;
        if (state_reg == ST_IDLE && req.start)
        begin
            tc_reg  <= req.tc;
            amp_reg <= req.amp;
        end
    end

    assign rsp.done  = (state_reg == ST_DONE);
    assign rsp.value = val_reg;

    // a start is only issued to an idle unit
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == ST_IDLE) else $error("start while busy");
    // a done pulse lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done) else $error("done held");
    // power steps never exceed cutoff
    a_pow_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POW |-> n_reg < 5'(mers_pkg::EXP_CUTOFF)) else $error("n range");

endmodule

### rtl/multi_exponential_residual_sum.sv
// ----------------------------------------------------------------------------
// multi_exponential_residual_sum: least-squares cost of a multi-exponential
// sum of squared residuals of y against 1 + sum amp * exp(-x / tc)
// ----------------------------------------------------------------------------
// - s_axis carries one point per beat: x_value, y_value, last_point in tlast
// - m_axis carries one result beat per data set, on the beat with tlast set
// - cfg_we / cfg_addr / cfg_wdata write the term count and term parameters;
//   write only while the block is idle
// - terms run one after another on one shared divide / exp unit: a term takes
//   a start, a divide, taylor steps (multiply, then reciprocal multiply),
//   power steps, an amplitude and a done step; a zero time constant goes
//   straight to done, a ratio past the cutoff to done after the divide
// - a point passes check, its terms, square, accumulate and emit;
//   a rejected point goes from check straight to emit
// - s_axis_tready is low from acceptance until the point is folded in
// - a result waits in an output register; while it is not taken the next
//   point is still accepted and computed, and only its own result waits
// - a point with a negative active parameter is not summed and marks the
//   set as rejected (result all ones, rejected and saturated set)
// - reset clears the sum and the flags and sets the configuration registers to their defaults
// ----------------------------------------------------------------------------
module multi_exponential_residual_sum
#(
    parameter int MAX_TERMS = mers_pkg::MAX_TERMS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // x_value [31:0], y_value [63:32]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // residual_sum [63:0]
    output logic [1:0]  m_axis_tuser,   // rejected [0], saturated [1]
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_SQ    = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    // configuration registers
    logic [1:0]  term_count_reg;
    logic [31:0] amp_reg [3];
    logic [31:0] tc_reg  [3];

    logic [2:0]  state_reg;
    logic [1:0]  idx_reg;
    logic [1:0]  count_reg;
    logic [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic        last_reg;
    logic [63:0] model_reg;
    logic [32:0] mag_reg;
    logic        big_reg;
    logic [63:0] sum_reg;
    logic        ovf_reg;
    logic        rej_reg;
    logic        out_valid_reg;
    logic [63:0] out_sum_reg;
    logic        out_rej_reg;
    logic        out_sat_reg;

    mers_pkg::term_req_t req;
    mers_pkg::term_rsp_t rsp;

    logic [1:0]  count_eff;
    logic        bad;
    logic signed [64:0] diff;
    logic [63:0] sq_val;
    logic [64:0] acc_sum;
    logic        emit_fire;

    always_comb
    begin
        count_eff = (term_count_reg == 2'd0) ? 2'd1 : term_count_reg;
        if (32'(count_eff) > 32'(MAX_TERMS))
            count_eff = 2'(MAX_TERMS);
        bad = 1'b0;
        for (int i = 0; i < 3; i++)
            if (i < int'(count_eff) && (amp_reg[i][31] || tc_reg[i][31]))
                bad = 1'b1;
    end

    assign req.start = (state_reg == ST_START);
    assign req.x     = x_reg;
    assign req.tc    = tc_reg[idx_reg];
    assign req.amp   = amp_reg[idx_reg];

    mers_term_unit u_term
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign diff    = 65'(signed'(y_reg)) - $signed({1'b0, model_reg});
    assign acc_sum = {1'b0, sum_reg} + {1'b0, sq_val};

    // the result of a closed set moves to the output register
    assign emit_fire = (state_reg == ST_EMIT) && last_reg && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= 2'd1;
            for (int i = 0; i < 3; i++)
            begin
                amp_reg[i] <= 32'd0;
                tc_reg[i]  <= 32'd65536;
            end
            state_reg     <= ST_IDLE;
            idx_reg       <= 2'd0;
            sum_reg       <= 64'd0;
            ovf_reg       <= 1'b0;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    mers_pkg::REG_TERM_COUNT: term_count_reg <= cfg_wdata[1:0];
                    mers_pkg::REG_AMP_1:      amp_reg[0] <= cfg_wdata;
                    mers_pkg::REG_TC_1:       tc_reg[0]  <= cfg_wdata;
                    mers_pkg::REG_AMP_2:      amp_reg[1] <= cfg_wdata;
                    mers_pkg::REG_TC_2:       tc_reg[1]  <= cfg_wdata;
                    mers_pkg::REG_AMP_3:      amp_reg[2] <= cfg_wdata;
                    mers_pkg::REG_TC_3:       tc_reg[2]  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (s_axis_tvalid)
                        state_reg <= ST_CHECK;
                ST_CHECK:
                begin
                    idx_reg <= 2'd0;
                    if (bad)
                    begin
                        rej_reg   <= 1'b1;
                        state_reg <= ST_EMIT;
                    end
                    else
                        state_reg <= ST_START;
                end
                ST_START: state_reg <= ST_WAIT;
                ST_WAIT:
                    if (rsp.done)
                    begin
                        if (idx_reg == count_reg - 2'd1)
                            state_reg <= ST_SQ;
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= ST_START;
                        end
                    end
                ST_SQ: state_reg <= ST_ACC;
                ST_ACC:
                begin
                    if (acc_sum[64] || acc_sum[63:0] == mers_pkg::SUM_MAX)
                    begin
                        sum_reg <= mers_pkg::SUM_MAX;
                        ovf_reg <= 1'b1;
                    end
                    else
                        sum_reg <= acc_sum[63:0];
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                    if (!last_reg)
                        state_reg <= ST_IDLE;
                    else if (emit_fire)
                    begin
                        sum_reg   <= 64'd0;
                        ovf_reg   <= 1'b0;
                        rej_reg   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            x_reg    <= s_axis_tdata[31:0];
            y_reg    <= s_axis_tdata[63:32];
            last_reg <= s_axis_tlast;
        end
        if (state_reg == ST_CHECK)
        begin
            model_reg <= 64'h1000_0000;
            count_reg <= count_eff;
        end
        if (state_reg == ST_WAIT && rsp.done)
            model_reg <= model_reg + {32'd0, rsp.value};
        if (state_reg == ST_SQ)
        begin
            mag_reg <= diff[64] ? 33'(-diff) : 33'(diff);
            big_reg <= diff[64] ? ((-diff) >= 65'sh1_0000_0000)
                                : (diff >= 65'sh1_0000_0000);
        end
        if (emit_fire)
        begin
            out_sum_reg <= rej_reg ? mers_pkg::SUM_MAX : sum_reg;
            out_rej_reg <= rej_reg;
            out_sat_reg <= rej_reg | ovf_reg;
        end
    end

    // square of the residual magnitude, 32 x 32
    assign sq_val = big_reg ? mers_pkg::SUM_MAX : mag_reg[31:0] * mag_reg[31:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sum_reg;
    assign m_axis_tuser  = {out_sat_reg, out_rej_reg};
    assign m_axis_tlast  = 1'b1;

    // a rejected result is always flagged saturated
    a_rej_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1]) else $error("rej sat");
    // a pending result is held until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    // term index stays below the active count
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WAIT |-> idx_reg < count_reg) else $error("idx range");

endmodule
